### design/ackermann_steer_speed_mapper_macros.svh
// Assertion macros used by the top-level design file.
`ifndef ACKERMANN_STEER_SPEED_MAPPER_MACROS_SVH
`define ACKERMANN_STEER_SPEED_MAPPER_MACROS_SVH
// Assert that an antecedent implies a consequent on the next clock edge.
`define ASM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
// Assert that a condition holds at every edge out of reset.
`define ASM_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`endif

### design/asm_pkg.sv
// ----------------------------------------------------------------------------
// Ackermann steer and speed mapper package
// Shared constants, the CORDIC angle table and the register address map.
// ----------------------------------------------------------------------------
package asm_pkg;
    localparam int ATAN_STEPS_DEF = 16;
    localparam int AtanMax = 24;
    localparam int XW = 34;
    localparam int ZW = 26;
    localparam int PADDR_W = 5;

    localparam logic [2:0] REG_MAX_SPEED = 3'd0;
    localparam logic [2:0] REG_MIN_SPEED = 3'd1;
    localparam logic [2:0] REG_WHEELBASE = 3'd2;
    localparam logic [2:0] REG_RPM_PER_SPEED = 3'd3;
    localparam logic [2:0] REG_STEER_MIN = 3'd4;
    localparam logic [2:0] REG_STEER_MAX = 3'd5;

    typedef struct packed {
        logic [14:0] max_speed;
        logic [14:0] min_speed;
        logic [14:0] wheelbase;
        logic [15:0] rpm_per_speed;
        logic signed [7:0] steer_min;
        logic [6:0] steer_max;
    } t_cfg;

    function automatic logic [ZW-1:0] atan_q16(input int i);
        logic [ZW-1:0] v;
        case (i)
            0: v = 26'd2949120;  1: v = 26'd1740967;  2: v = 26'd919879;
            3: v = 26'd466945;   4: v = 26'd234379;   5: v = 26'd117304;
            6: v = 26'd58666;    7: v = 26'd29335;    8: v = 26'd14668;
            9: v = 26'd7334;     10: v = 26'd3667;    11: v = 26'd1833;
            12: v = 26'd917;     13: v = 26'd458;     14: v = 26'd229;
            15: v = 26'd115;     16: v = 26'd57;      17: v = 26'd29;
            18: v = 26'd14;      19: v = 26'd7;       20: v = 26'd4;
            21: v = 26'd2;       22: v = 26'd1;       default: v = 26'd0;
        endcase
        return v;
    endfunction
endpackage

### design/asm_cordic_stage.sv
// ----------------------------------------------------------------------------
// CORDIC vectoring stage
// One registered micro-rotation of the steering angle pipeline.
// ----------------------------------------------------------------------------
module asm_cordic_stage import asm_pkg::*; #(
    parameter int STEP = 0
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [XW-1:0] i_x,
    input  logic signed [XW-1:0] i_y,
    input  logic signed [ZW-1:0] i_z,
    output logic signed [XW-1:0] o_x,
    output logic signed [XW-1:0] o_y,
    output logic signed [ZW-1:0] o_z
);
    logic signed [XW-1:0] r_x, r_y;
    logic signed [ZW-1:0] r_z;
    logic signed [XW-1:0] dx, dy;
    logic signed [ZW-1:0] a;

    assign dx = i_y >>> STEP;
    assign dy = i_x >>> STEP;
    assign a  = atan_q16(STEP);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_y > 0) begin
                r_x <= i_x + dx;
                r_y <= i_y - dy;
                r_z <= i_z + a;
            end else begin
                r_x <= i_x - dx;
                r_y <= i_y + dy;
                r_z <= i_z - a;
            end
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;
endmodule

### design/asm_cfg_regs.sv
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file holding the mapper's settings.
// ----------------------------------------------------------------------------
module asm_cfg_regs import asm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output t_cfg               o_cfg
);
    t_cfg r_cfg;
    logic [2:0] idx;

    assign idx = paddr[4:2];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_speed <= 15'd4096;
            r_cfg.min_speed <= 15'd205;
            r_cfg.wheelbase <= 15'd758;
            r_cfg.rpm_per_speed <= 16'd48893;
            r_cfg.steer_min <= -8'sd30;
            r_cfg.steer_max <= 7'd30;
        end else if (psel && penable && pwrite && pready) begin
            case (idx)
                REG_MAX_SPEED: r_cfg.max_speed <= pwdata[14:0];
                REG_MIN_SPEED: r_cfg.min_speed <= pwdata[14:0];
                REG_WHEELBASE: r_cfg.wheelbase <= pwdata[14:0];
                REG_RPM_PER_SPEED: r_cfg.rpm_per_speed <= pwdata[15:0];
                REG_STEER_MIN: r_cfg.steer_min <= pwdata[7:0];
                REG_STEER_MAX: r_cfg.steer_max <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_MAX_SPEED: prdata = {17'd0, r_cfg.max_speed};
            REG_MIN_SPEED: prdata = {17'd0, r_cfg.min_speed};
            REG_WHEELBASE: prdata = {17'd0, r_cfg.wheelbase};
            REG_RPM_PER_SPEED: prdata = {16'd0, r_cfg.rpm_per_speed};
            REG_STEER_MIN: prdata = {24'd0, r_cfg.steer_min};
            REG_STEER_MAX: prdata = {25'd0, r_cfg.steer_max};
            default: prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;
endmodule

### design/ackermann_steer_speed_mapper.sv
// Each accepted item passes stage 0, stage 1, the CORDIC stages and the output register in order.
// Throughput: one item per cycle unless stalled; the CORDIC is fully unrolled into registered stages.
// A stall freezes the whole pipeline, so nothing is lost or repeated.
// Reset clears the valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
// Ackermann steer and speed mapper
// Maps a speed and turn-rate command to wheel rpm targets and a steering angle.
// ----------------------------------------------------------------------------
`include "ackermann_steer_speed_mapper_macros.svh"
module ackermann_steer_speed_mapper import asm_pkg::*; #(
    parameter int ATAN_STEPS = ATAN_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_linear_speed,
    input  logic signed [15:0] i_turn_rate,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_left_target_rpm,
    output logic signed [15:0] o_right_target_rpm,
    output logic signed [7:0]  o_steering_angle,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    localparam int NS = (ATAN_STEPS < AtanMax) ? ATAN_STEPS : AtanMax;
    localparam int DEPTH = NS + 3;

    t_cfg cfg;
    logic adv;
    logic [DEPTH-1:0] r_vld;

    asm_cfg_regs u_regs (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready), .o_cfg(cfg)
    );

    assign adv = !(r_vld[DEPTH-1] && i_stall);
    assign o_stall = !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[DEPTH-2:0], i_valid};
        end
    end

    // Stage 0: clamp, speed product, steer setup.
    logic signed [16:0] cs;
    logic [15:0] mag;
    logic signed [32:0] r_prod;
    logic signed [30:0] wr;
    logic signed [XW-1:0] r_x0, r_y0;
    logic [1:0] r_mode0;
    logic signed [7:0] r_fix0;
    logic signed [16:0] lim;

    assign lim = $signed({2'b00, cfg.max_speed});
    assign mag = i_linear_speed[15] ? 16'(-i_linear_speed) : 16'(i_linear_speed);
    assign wr = $signed({1'b0, cfg.wheelbase}) * i_turn_rate;

    always_comb begin
        cs = 17'(i_linear_speed);
        if (cs > lim) cs = lim;
        if (cs < -lim) cs = -lim;
    end

    // mode: 0 = cordic, 1 = fixed angle
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_prod <= 33'(cs) * $signed({17'd0, cfg.rpm_per_speed});
            r_x0 <= XW'({mag, 12'd0});
            r_y0 <= i_linear_speed[15] ? -XW'(wr) : XW'(wr);
            r_mode0 <= 2'd0;
            r_fix0 <= 8'sd0;
            if (i_turn_rate == 16'sd0) begin
                r_mode0 <= 2'd1;
            end else if ({1'b0, mag} < {2'b0, cfg.min_speed} || mag == 16'd0) begin
                r_mode0 <= 2'd1;
                r_fix0 <= i_turn_rate > 0 ? $signed({1'b0, cfg.steer_max}) : cfg.steer_min;
            end
        end
    end

    // Stage 1: rpm rounding; carried alongside CORDIC stages.
    logic signed [15:0] r_rpm [NS+1];
    logic signed [15:0] r_lrpm [NS+1];
    logic [1:0] r_mode [NS+1];
    logic signed [7:0] r_fix [NS+1];
    logic signed [17:0] rnd;
    logic [32:0] pa;

    always_comb begin
        pa = r_prod[32] ? 33'(-r_prod) : 33'(r_prod);
        rnd = 18'((pa + 33'd32768) >> 16);
        if (r_prod[32]) rnd = -rnd;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rpm[0] <= rnd > 18'sd32767 ? 16'sd32767 :
                        (rnd < -18'sd32768 ? -16'sd32768 : 16'(rnd));
            r_lrpm[0] <= rnd < -18'sd32767 ? 16'sd32767 :
                         (rnd > 18'sd32767 ? -16'sd32767 : 16'(-rnd));
            r_mode[0] <= r_mode0;
            r_fix[0] <= r_fix0;
            for (int k = 1; k <= NS; k++) begin
                r_rpm[k] <= r_rpm[k-1];
                r_lrpm[k] <= r_lrpm[k-1];
                r_mode[k] <= r_mode[k-1];
                r_fix[k] <= r_fix[k-1];
            end
        end
    end

    logic signed [XW-1:0] xs [NS+1];
    logic signed [XW-1:0] ys [NS+1];
    logic signed [ZW-1:0] zs [NS+1];
    logic signed [XW-1:0] r_xa, r_ya;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_xa <= r_x0;
            r_ya <= r_y0;
        end
    end
    assign xs[0] = r_xa;
    assign ys[0] = r_ya;
    assign zs[0] = '0;

    for (genvar g = 0; g < NS; g++) begin : g_cordic
        asm_cordic_stage #(.STEP(g)) u_stage (
            .i_clk(i_clk), .i_en(adv), .i_x(xs[g]), .i_y(ys[g]), .i_z(zs[g]),
            .o_x(xs[g+1]), .o_y(ys[g+1]), .o_z(zs[g+1])
        );
    end

    // Final stage: pick the fixed angle or clamp and round the CORDIC angle; register all outputs.
    logic signed [ZW-1:0] z, zmin, zmax, za;
    logic signed [7:0] ang;
    logic signed [15:0] r_out_l, r_out_r;
    logic signed [7:0] r_out_a;

    assign z = zs[NS];
    assign zmin = ZW'(cfg.steer_min) <<< 16;
    assign zmax = ZW'($signed({1'b0, cfg.steer_max})) <<< 16;
    assign za = z[ZW-1] ? -z : z;

    always_comb begin
        if (r_mode[NS] == 2'd1) ang = r_fix[NS];
        else if (z < zmin) ang = cfg.steer_min;
        else if (z > zmax) ang = $signed({1'b0, cfg.steer_max});
        else if (z[ZW-1]) ang = -8'(ZW'(za + 26'sd32768) >>> 16);
        else ang = 8'(ZW'(za + 26'sd32768) >>> 16);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_l <= r_lrpm[NS];
            r_out_r <= r_rpm[NS];
            r_out_a <= ang;
        end
    end

    assign o_valid = r_vld[DEPTH-1];
    assign o_left_target_rpm = r_out_l;
    assign o_right_target_rpm = r_out_r;
    assign o_steering_angle = r_out_a;

    `ASM_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, o_valid && i_stall, o_valid, "result dropped while stalled")
    `ASM_ASSERT_ALWAYS(a_stall_only_full, i_clk, i_rst_n, !o_stall || o_valid, "stall without a waiting result")
    `ASM_ASSERT_NEXT(a_flow, i_clk, i_rst_n, !o_stall && !r_vld[DEPTH-2], !o_valid || $past(i_stall), "valid bit invented")
endmodule

### tb/asm_checker.sv
// ----------------------------------------------------------------------------
// Steer and speed mapper checker
// Watches the command and result channels, computes the expected wheel
// targets and steering angle for each accepted item, and compares in order.
// ----------------------------------------------------------------------------
module asm_checker import asm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_in_stall,
    input  logic signed [15:0] i_linear_speed,
    input  logic signed [15:0] i_turn_rate,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic signed [15:0] i_left_target_rpm,
    input  logic signed [15:0] i_right_target_rpm,
    input  logic signed [7:0]  i_steering_angle,
    input  t_cfg               i_cfg,
    output int                 o_failures,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [15:0] left_rpm;
        logic signed [15:0] right_rpm;
        logic signed [7:0]  angle;
    } t_targets;

    t_targets expected_targets[$];

    function automatic longint floor_shift(longint v, int s);
        if (v >= 0) return v >>> s;
        return -(((-v) - 1) >>> s) - 1;
    endfunction

    function automatic longint round_q16(longint v);
        if (v >= 0) return (v + 32768) >>> 16;
        return -(((-v) + 32768) >>> 16);
    endfunction

    function automatic longint clip16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint steer_deg(longint spd, longint rate, t_cfg c);
        longint smin, smax, mag, x, y, z, dx, dy;
        smin = longint'(c.steer_min);
        smax = longint'(c.steer_max);
        mag = spd < 0 ? -spd : spd;
        z = 0;
        if (rate == 0) return 0;
        if (mag < longint'(c.min_speed) || mag == 0) return rate > 0 ? smax : smin;
        x = mag << 12;
        y = longint'(c.wheelbase) * rate;
        if (spd < 0) y = -y;
        for (int i = 0; i < ATAN_STEPS_DEF && i < AtanMax; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (y > 0) begin
                x += dx; y -= dy; z += longint'(atan_q16(i));
            end else begin
                x -= dx; y += dy; z -= longint'(atan_q16(i));
            end
        end
        if (z < smin * 65536) return smin;
        if (z > smax * 65536) return smax;
        return round_q16(z);
    endfunction

    function automatic t_targets map_command(longint spd, longint rate, t_cfg c);
        t_targets t;
        longint lim, cs, right;
        lim = longint'(c.max_speed);
        cs = spd;
        if (cs > lim) cs = lim;
        if (cs < -lim) cs = -lim;
        right = clip16(round_q16(cs * longint'(c.rpm_per_speed)));
        t.right_rpm = right[15:0];
        t.left_rpm = 16'(clip16(-right));
        t.angle = 8'(steer_deg(spd, rate, c));
        return t;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        o_failures++;
    endtask

    initial begin
        o_failures = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_targets want;
        if (i_rst_n && i_valid && !i_in_stall)
            expected_targets.push_back(map_command(i_linear_speed, i_turn_rate, i_cfg));
        if (i_rst_n && i_out_valid && !i_out_stall) begin
            if (expected_targets.size() == 0) begin
                report_mismatch("unexpected result", 0, 0);
            end else begin
                want = expected_targets.pop_front();
                if (i_left_target_rpm !== want.left_rpm)
                    report_mismatch("left rpm", i_left_target_rpm, want.left_rpm);
                if (i_right_target_rpm !== want.right_rpm)
                    report_mismatch("right rpm", i_right_target_rpm, want.right_rpm);
                if (i_steering_angle !== want.angle)
                    report_mismatch("angle", i_steering_angle, want.angle);
            end
        end
        o_pending = expected_targets.size();
    end
endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// Steer and speed mapper testbench
// Writes the registers through the APB port in several settings, sends
// directed and random commands under varied idling, and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top import asm_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int Latency = 30;
    localparam longint CycleLimit = 800000;

    logic i_clk, i_rst_n, i_valid, o_stall, o_valid, i_stall;
    logic signed [15:0] i_linear_speed, i_turn_rate;
    logic signed [15:0] o_left_target_rpm, o_right_target_rpm;
    logic signed [7:0] o_steering_angle;
    logic psel, penable, pwrite, pready;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata, prdata;
    t_cfg cfg;
    int failures, pending;
    int send_idle_pct, recv_stall_pct;
    longint cycles;

    ackermann_steer_speed_mapper dut (.*);

    asm_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_in_stall(o_stall),
        .i_linear_speed(i_linear_speed), .i_turn_rate(i_turn_rate),
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_left_target_rpm(o_left_target_rpm), .i_right_target_rpm(o_right_target_rpm),
        .i_steering_angle(o_steering_angle), .i_cfg(cfg),
        .o_failures(failures), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CycleLimit) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    always @(posedge i_clk)
        i_stall <= ($urandom_range(99) < recv_stall_pct);

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        @(posedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= PADDR_W'(idx) << 2; pwdata <= value;
        @(posedge i_clk);
        penable <= 1;
        do @(posedge i_clk); while (!pready);
        psel <= 0; penable <= 0; pwrite <= 0;
        case (idx)
            REG_MAX_SPEED: cfg.max_speed = value[14:0];
            REG_MIN_SPEED: cfg.min_speed = value[14:0];
            REG_WHEELBASE: cfg.wheelbase = value[14:0];
            REG_RPM_PER_SPEED: cfg.rpm_per_speed = value[15:0];
            REG_STEER_MIN: cfg.steer_min = value[7:0];
            default: cfg.steer_max = value[6:0];
        endcase
    endtask

    task automatic configure(int ms, int mn, int wb, int rp, int smin, int smax);
        write_reg(REG_MAX_SPEED, ms);
        write_reg(REG_MIN_SPEED, mn);
        write_reg(REG_WHEELBASE, wb);
        write_reg(REG_RPM_PER_SPEED, rp);
        write_reg(REG_STEER_MIN, 32'(smin));
        write_reg(REG_STEER_MAX, smax);
    endtask

    task automatic send_command(logic [15:0] spd, logic [15:0] rate);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1;
        i_linear_speed <= spd;
        i_turn_rate <= rate;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic drain();
        i_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (Latency) @(posedge i_clk);
    endtask

    task automatic random_commands(int n);
        logic [15:0] spd, rate;
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(5))
                0: spd = 16'($urandom);
                1: spd = 16'($signed($urandom_range(600)) - 300);
                2: spd = 0;
                default: spd = 16'($signed($urandom_range(12000)) - 6000);
            endcase
            case ($urandom_range(5))
                0: rate = 16'($urandom);
                1: rate = 0;
                2: rate = $urandom_range(1) ? 16'h8000 : 16'h7fff;
                default: rate = 16'($signed($urandom_range(8000)) - 4000);
            endcase
            send_command(spd, rate);
            if (k == n / 2 && n > 100) drain();
        end
    endtask

    initial begin
        logic [15:0] corner[6] = '{16'h8000, 16'h7fff, 16'h0000, 16'h0001,
                                   16'hffff, 16'h00cc};
        i_rst_n = 0; i_valid = 0; i_linear_speed = 0; i_turn_rate = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        send_idle_pct = 0; recv_stall_pct = 0;
        cfg = '{15'd4096, 15'd205, 15'd758, 16'd48893, -8'sd30, 7'd30};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        foreach (corner[a]) foreach (corner[b]) send_command(corner[a], corner[b]);
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            case (phase)
                0: configure(4096, 205, 758, 48893, -30, 30);
                1: configure(32767, 0, 32767, 65535, -90, 90);
                2: configure(0, 32767, 1, 1, 0, 0);
                3: configure(20000, 100, 0, 40000, -5, 60);
                4: configure(32767, 1, 32767, 65535, 0, 90);
                5: configure(1000, 0, 4000, 30000, -90, 0);
                default: configure($urandom_range(32767), $urandom_range(600),
                                   $urandom_range(32767), $urandom_range(65535),
                                   -$signed($urandom_range(90)), $urandom_range(90));
            endcase
            random_commands(200);
            drain();
        end

        if (failures == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
